@@ rtl/core/square_triangle_sine_generator_top_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the square / triangle / sine generator
// ----------------------------------------------------------------------------
`ifndef SQUARE_TRIANGLE_SINE_GENERATOR_TOP_MACROS_SVH
`define SQUARE_TRIANGLE_SINE_GENERATOR_TOP_MACROS_SVH

// property that must hold on every clock outside reset
`define STSG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define STSG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/stsg_pkg.sv @@
// ----------------------------------------------------------------------------
// stsg_pkg
// shared constants, codes and the quarter-wave sine table of the generator
// ----------------------------------------------------------------------------
package stsg_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int LEVEL_W    = 18;
	localparam int INDEX_W    = 16;
	localparam int GAIN_W     = 15;
	localparam int STEP_W     = 15;
	localparam int MODE_W     = 2;
	localparam int CFG_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	localparam int PHASE_BITS       = 32;
	localparam int FRAC_BITS        = PHASE_BITS - 2;
	localparam int SINE_TABLE_DEPTH = 256;
	localparam int TAB_IDX_W        = $clog2(SINE_TABLE_DEPTH);
	localparam int TAB_ADDR_W       = TAB_IDX_W + 1;
	localparam int MAG_W            = 15;
	localparam int PROD_W           = GAIN_W + MAG_W;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_SQUARE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TRIANGLE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SINE     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SILENT   = 2'd3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD_LEN = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN       = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TRI_STEP   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = 3'd4;

	// register reset values
	localparam logic [MODE_W-1:0]     RST_MODE       = MODE_SQUARE;
	localparam logic [INDEX_W-1:0]    RST_PERIOD_LEN = 16'd160;
	localparam logic [GAIN_W-1:0]     RST_GAIN       = 15'd1000;
	localparam logic [STEP_W-1:0]     RST_TRI_STEP   = 15'd25;
	localparam logic [PHASE_BITS-1:0] RST_PHASE_STEP = PHASE_BITS'(26843546);

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic [MAG_W-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];

	// quarter-wave table in Q1.15, taylor series to the x^11 term in Q2.30
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t t;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			x    = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			term = ((term * x2) >> 30) / 6;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 30) / 20;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 30) / 42;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 30) / 72;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 30) / 110;
			sum  = sum - longint'(term);
			if (sum < 0) begin
				sum = 0;
			end
			sum = (sum * 32767 + (longint'(1) << 29)) >>> 30;
			if (sum > 32767) begin
				sum = 32767;
			end
			t[k] = MAG_W'(sum);
		end
		t[SINE_TABLE_DEPTH] = MAG_W'(32767);
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

@@ rtl/core/stsg_tick_if.sv @@
// ----------------------------------------------------------------------------
// stsg_tick_if
// input channel: one tick word per sample, carrying the restart flag
// ----------------------------------------------------------------------------
interface stsg_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

@@ rtl/core/stsg_result_if.sv @@
// ----------------------------------------------------------------------------
// stsg_result_if
// output channel: one sample word with its period wrap flag
// ----------------------------------------------------------------------------
interface stsg_result_if;
	import stsg_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       period_wrap;

	modport source (output valid, output sample, output period_wrap, input ready);
	modport sink   (input valid, input sample, input period_wrap, output ready);
endinterface

@@ rtl/core/stsg_sine.sv @@
// ----------------------------------------------------------------------------
// stsg_sine
// quarter-wave lookup and gain scaling of the sine for a given phase
// ----------------------------------------------------------------------------
module stsg_sine (
	input  logic [stsg_pkg::PHASE_BITS-1:0]      phase,
	input  logic [stsg_pkg::GAIN_W-1:0]          gain,
	output logic signed [stsg_pkg::SAMPLE_W-1:0] value
);
	import stsg_pkg::*;

	logic [1:0]            quad;
	logic [TAB_IDX_W-1:0]  idx;
	logic [TAB_ADDR_W-1:0] addr;
	logic [MAG_W-1:0]      mag;
	logic [PROD_W-1:0]     prod;
	logic [MAG_W-1:0]      scaled;

	assign quad = phase[PHASE_BITS-1 -: 2];
	assign idx  = phase[FRAC_BITS-1 -: TAB_IDX_W];

	// odd quadrants run the table backwards
	assign addr = quad[0] ? (TAB_ADDR_W'(SINE_TABLE_DEPTH) - {1'b0, idx}) : {1'b0, idx};
	assign mag  = SINE_TAB[addr];

	assign prod   = PROD_W'(gain) * PROD_W'(mag);
	assign scaled = prod[PROD_W-1 -: MAG_W];

	always_comb begin
		if (quad[1]) begin
			value = -$signed({1'b0, scaled});
		end else begin
			value = $signed({1'b0, scaled});
		end
	end
endmodule

@@ rtl/core/square_triangle_sine_generator_top.sv @@
// ----------------------------------------------------------------------------
// square_triangle_sine_generator_top: sample valid in the cycle after the tick is accepted
// throughput one word per cycle while the output is not stalled, set by the state update loop
// reset: mode square, period 160, gain 1000, step 25, phase step 26843546
// ----------------------------------------------------------------------------
module square_triangle_sine_generator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [stsg_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [stsg_pkg::CFG_DATA_W-1:0]   cfg_data,
	stsg_tick_if.sink                         tick,
	stsg_result_if.source                     result
);
	import stsg_pkg::*;

	`include "square_triangle_sine_generator_top_macros.svh"

	logic [MODE_W-1:0]     mode_q;
	logic [INDEX_W-1:0]    period_len_q;
	logic [GAIN_W-1:0]     gain_q;
	logic [STEP_W-1:0]     tri_step_q;
	logic [PHASE_BITS-1:0] phase_step_q;

	logic [INDEX_W-1:0]        index_q;
	logic signed [LEVEL_W-1:0] level_q;
	logic                      rising_q;
	logic [PHASE_BITS-1:0]     phase_q;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       wrap_q;

	logic accept;

	logic [INDEX_W-1:0]        index0;
	logic signed [LEVEL_W-1:0] level0;
	logic                      rising0;
	logic [PHASE_BITS-1:0]     phase0;

	logic signed [SAMPLE_W-1:0] sine_val;
	logic signed [LEVEL_W-1:0]  gain_ext;
	logic signed [LEVEL_W-1:0]  low_bound;
	logic signed [LEVEL_W-1:0]  step_ext;
	logic signed [LEVEL_W-1:0]  level_up;
	logic signed [LEVEL_W-1:0]  level_dn;

	logic signed [LEVEL_W-1:0] level1;
	logic                      rising1;
	logic [PHASE_BITS-1:0]     phase1;
	logic [INDEX_W:0]          index_inc;
	logic                      wrap_now;

	logic [INDEX_W-1:0]         index_nx;
	logic signed [LEVEL_W-1:0]  level_nx;
	logic [PHASE_BITS-1:0]      phase_nx;
	logic signed [SAMPLE_W-1:0] sample_nx;

	assign tick.ready = !out_valid_q || result.ready;
	assign accept     = tick.valid && tick.ready;

	assign result.valid       = out_valid_q;
	assign result.sample      = sample_q;
	assign result.period_wrap = wrap_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= RST_MODE;
			period_len_q <= RST_PERIOD_LEN;
			gain_q       <= RST_GAIN;
			tri_step_q   <= RST_TRI_STEP;
			phase_step_q <= RST_PHASE_STEP;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MODE:       mode_q       <= cfg_data[MODE_W-1:0];
				REG_PERIOD_LEN: period_len_q <= cfg_data[INDEX_W-1:0];
				REG_GAIN:       gain_q       <= cfg_data[GAIN_W-1:0];
				REG_TRI_STEP:   tri_step_q   <= cfg_data[STEP_W-1:0];
				REG_PHASE_STEP: phase_step_q <= cfg_data[PHASE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// restart clears the state before this sample
	assign index0  = tick.restart ? '0 : index_q;
	assign level0  = tick.restart ? '0 : level_q;
	assign rising0 = tick.restart ? 1'b1 : rising_q;
	assign phase0  = tick.restart ? '0 : phase_q;

	stsg_sine u_sine (
		.phase (phase0),
		.gain  (gain_q),
		.value (sine_val)
	);

	assign gain_ext  = $signed({{(LEVEL_W-GAIN_W){1'b0}}, gain_q});
	assign low_bound = ~gain_ext;
	assign step_ext  = $signed({{(LEVEL_W-STEP_W){1'b0}}, tri_step_q});

	// reflecting by twice the step lands on the opposite single step
	assign level_up = level0 + step_ext;
	assign level_dn = level0 - step_ext;

	always_comb begin
		level1  = '0;
		rising1 = rising0;
		case (mode_q)
			MODE_SQUARE: begin
				level1 = (index0 < (period_len_q >> 1)) ? gain_ext : low_bound;
			end
			MODE_TRIANGLE: begin
				if (rising0) begin
					if (level_up > gain_ext) begin
						level1  = level_dn;
						rising1 = 1'b0;
					end else begin
						level1 = level_up;
					end
				end else begin
					if (level_dn < low_bound) begin
						level1  = level_up;
						rising1 = 1'b1;
					end else begin
						level1 = level_dn;
					end
				end
			end
			MODE_SINE: begin
				level1 = LEVEL_W'(sine_val);
			end
			default: begin
				level1 = '0;
			end
		endcase
	end

	assign phase1    = phase0 + phase_step_q;
	assign index_inc = {1'b0, index0} + (INDEX_W+1)'(1);
	assign wrap_now  = index_inc >= {1'b0, period_len_q};

	assign index_nx = wrap_now ? '0 : index_inc[INDEX_W-1:0];
	assign level_nx = (wrap_now && (mode_q != MODE_SQUARE)) ? '0 : level1;
	assign phase_nx = (wrap_now && (mode_q != MODE_SQUARE)) ? '0 : phase1;

	// saturate when the bits above the sample do not all match its sign
	always_comb begin
		if ((level_nx[LEVEL_W-1 -: (LEVEL_W-SAMPLE_W+1)] == '0) ||
			(level_nx[LEVEL_W-1 -: (LEVEL_W-SAMPLE_W+1)] == '1)) begin
			sample_nx = level_nx[SAMPLE_W-1:0];
		end else if (level_nx[LEVEL_W-1]) begin
			sample_nx = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			sample_nx = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q  <= '0;
			level_q  <= '0;
			rising_q <= 1'b1;
			phase_q  <= '0;
		end else if (accept) begin
			index_q  <= index_nx;
			level_q  <= level_nx;
			rising_q <= rising1;
			phase_q  <= phase_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_nx;
			wrap_q   <= wrap_now;
		end
	end

	`STSG_ASSERT(a_ready_when_empty, !out_valid_q |-> tick.ready, "tick stalled with empty output")
	`STSG_ASSERT_NEXT(a_accept_gives_word, accept, out_valid_q, "accepted tick gave no sample")
	`STSG_ASSERT_NEXT(a_wrap_zero, accept && wrap_now && (mode_q != MODE_SQUARE), sample_q == '0, "non-square wrap sample not zero")
	`STSG_ASSERT_NEXT(a_restart_index, accept && tick.restart, (index_q == '0) || (index_q == INDEX_W'(1)), "restart did not reset index")
endmodule

@@ tb/sv/stsg_sample_checker.sv @@
// ----------------------------------------------------------------------------
// stsg_sample_checker
// watches the tick, result and register ports of the generator, keeps its own
// copy of the registers and of the waveform state, predicts every sample word
// and compares each result word with the oldest prediction
// ----------------------------------------------------------------------------
module stsg_sample_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [stsg_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [stsg_pkg::CFG_DATA_W-1:0] cfg_data,
	stsg_tick_if                            tick,
	stsg_result_if                          result,
	output int                              errors,
	output int                              pending,
	output int                              checked,
	output int                              wraps
);
	import stsg_pkg::*;

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       period_wrap;
	} gen_word_t;

	localparam u64_t QUARTER_TURN_Q30 = 64'd1686629713;

	// quarter-wave magnitudes, q1.15
	int unsigned qsine [0:SINE_TABLE_DEPTH];

	// register copies
	logic [MODE_W-1:0]     cur_mode;
	logic [INDEX_W-1:0]    cur_period;
	logic [GAIN_W-1:0]     cur_gain;
	logic [STEP_W-1:0]     cur_tri_step;
	logic [PHASE_BITS-1:0] cur_phase_step;

	// waveform state
	logic [INDEX_W-1:0]        pos;
	logic signed [LEVEL_W-1:0] lvl;
	logic                      going_up;
	logic [PHASE_BITS-1:0]     acc_phase;

	gen_word_t expected_words [$];

	function automatic int unsigned taylor_entry(input int k);
		u64_t   x;
		u64_t   x2;
		u64_t   term;
		longint acc;
		x    = (u64_t'(k) * QUARTER_TURN_Q30) / SINE_TABLE_DEPTH;
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		// odd powers up to x^11, alternating sign
		for (int n = 1; n <= 5; n++) begin
			term = ((term * x2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
			acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
		end
		if (acc < 0) begin
			acc = 0;
		end
		acc = (acc * 32767 + (longint'(1) << 29)) >>> 30;
		if (acc > 32767) begin
			acc = 32767;
		end
		return 32'(acc);
	endfunction

	initial begin
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			qsine[k] = taylor_entry(k);
		end
		qsine[SINE_TABLE_DEPTH] = 32767;
	end

	function automatic int sine_level();
		logic [1:0]  quad;
		int unsigned slot;
		int unsigned mag;
		int unsigned prod;
		quad = acc_phase[PHASE_BITS-1 -: 2];
		slot = 32'((u64_t'(acc_phase[FRAC_BITS-1:0]) * SINE_TABLE_DEPTH) >> FRAC_BITS);
		if (slot > SINE_TABLE_DEPTH) begin
			slot = SINE_TABLE_DEPTH;
		end
		// odd quadrants run the table backwards, upper half is negative
		mag  = quad[0] ? qsine[SINE_TABLE_DEPTH - slot] : qsine[slot];
		prod = (32'(cur_gain) * mag) >> 15;
		return quad[1] ? -int'(prod) : int'(prod);
	endfunction

	function automatic gen_word_t next_sample(input logic restart);
		int          g;
		int          st;
		int unsigned nxt;
		gen_word_t   w;
		g  = int'(cur_gain);
		st = int'(cur_tri_step);
		if (restart) begin
			pos       = '0;
			lvl       = '0;
			going_up  = 1'b1;
			acc_phase = '0;
		end
		case (cur_mode)
			MODE_SQUARE: begin
				lvl = (pos < (cur_period >> 1)) ? LEVEL_W'(g) : LEVEL_W'(-g - 1);
			end
			MODE_TRIANGLE: begin
				if (going_up) begin
					lvl = LEVEL_W'(int'(lvl) + st);
					if (lvl > g) begin
						going_up = 1'b0;
						lvl      = LEVEL_W'(int'(lvl) - 2 * st);
					end
				end else begin
					lvl = LEVEL_W'(int'(lvl) - st);
					if (lvl < -g - 1) begin
						going_up = 1'b1;
						lvl      = LEVEL_W'(int'(lvl) + 2 * st);
					end
				end
			end
			MODE_SINE: begin
				lvl = LEVEL_W'(sine_level());
			end
			default: begin
				lvl = '0;
			end
		endcase
		acc_phase     = acc_phase + cur_phase_step;
		nxt           = 32'(pos) + 1;
		w.period_wrap = 1'b0;
		if (nxt >= 32'(cur_period)) begin
			nxt           = 0;
			w.period_wrap = 1'b1;
			// only square keeps its level across the period end
			if (cur_mode != MODE_SQUARE) begin
				lvl       = '0;
				acc_phase = '0;
			end
		end
		pos = nxt[INDEX_W-1:0];
		if (lvl > 32767) begin
			w.sample = 16'sh7fff;
		end else if (lvl < -32768) begin
			w.sample = 16'sh8000;
		end else begin
			w.sample = lvl[SAMPLE_W-1:0];
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gen_word_t want;
		if (!arst_n) begin
			cur_mode       = RST_MODE;
			cur_period     = RST_PERIOD_LEN;
			cur_gain       = RST_GAIN;
			cur_tri_step   = RST_TRI_STEP;
			cur_phase_step = RST_PHASE_STEP;
			pos            = '0;
			lvl            = '0;
			going_up       = 1'b1;
			acc_phase      = '0;
			expected_words.delete();
			errors         = 0;
			checked        = 0;
			wraps          = 0;
			pending       <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MODE:       cur_mode       = cfg_data[MODE_W-1:0];
					REG_PERIOD_LEN: cur_period     = cfg_data[INDEX_W-1:0];
					REG_GAIN:       cur_gain       = cfg_data[GAIN_W-1:0];
					REG_TRI_STEP:   cur_tri_step   = cfg_data[STEP_W-1:0];
					REG_PHASE_STEP: cur_phase_step = cfg_data[PHASE_BITS-1:0];
					default: ;
				endcase
			end
			if (tick.valid && tick.ready) begin
				expected_words.push_back(next_sample(tick.restart));
			end
			if (result.valid && result.ready) begin
				if (expected_words.size() == 0) begin
					errors++;
					$display("%0t unexpected sample word: expected none, got %0d",
						$time, result.sample);
				end else begin
					want = expected_words.pop_front();
					checked++;
					if (want.sample !== result.sample) begin
						errors++;
						$display("%0t sample: expected %0d, got %0d",
							$time, want.sample, result.sample);
					end
					if (want.period_wrap !== result.period_wrap) begin
						errors++;
						$display("%0t period_wrap: expected %0b, got %0b",
							$time, want.period_wrap, result.period_wrap);
					end
					if (result.period_wrap === 1'b1) begin
						wraps++;
					end
				end
			end
			pending <= expected_words.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives ticks and register writes into the square / triangle / sine
// generator: a short directed pass over all modes and edge settings, then
// random register settings with random restarts, random idling on both
// sides, one long output hold-off and one stretch without idling
// ----------------------------------------------------------------------------
module testbench;
	import stsg_pkg::*;

	localparam int RANDOM_TICKS = 1350;
	localparam int HOLD_CYCLES  = 80;
	localparam int IDLE_PCT     = 27;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [REG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int errors;
	int pending;
	int checked;
	int wraps;
	int ticks_sent;
	int settings_used;
	int holds;
	bit steady;
	bit hold_req;

	stsg_tick_if   tick ();
	stsg_result_if result ();

	square_triangle_sine_generator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick),
		.result    (result)
	);

	stsg_sample_checker sample_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick),
		.result    (result),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked),
		.wraps     (wraps)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// stop offering and wait for every predicted word to come back
	task automatic drain();
		tick.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic apply_setting(input logic [MODE_W-1:0] m, input logic [INDEX_W-1:0] plen,
		input logic [GAIN_W-1:0] g, input logic [STEP_W-1:0] st,
		input logic [PHASE_BITS-1:0] ps);
		drain();
		write_reg(REG_MODE, CFG_DATA_W'(m));
		write_reg(REG_PERIOD_LEN, CFG_DATA_W'(plen));
		write_reg(REG_GAIN, CFG_DATA_W'(g));
		write_reg(REG_TRI_STEP, CFG_DATA_W'(st));
		write_reg(REG_PHASE_STEP, CFG_DATA_W'(ps));
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	task automatic send_tick(input logic rst);
		// idle decided cycle by cycle
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			tick.valid <= 1'b0;
			@(posedge clk);
		end
		tick.valid   <= 1'b1;
		tick.restart <= rst;
		do @(posedge clk); while (!tick.ready);
		ticks_sent++;
	endtask

	task automatic random_setting();
		logic [MODE_W-1:0]     m;
		logic [INDEX_W-1:0]    plen;
		logic [GAIN_W-1:0]     g;
		logic [STEP_W-1:0]     st;
		logic [PHASE_BITS-1:0] ps;
		int                    quarter;
		m = MODE_W'($urandom_range(MODE_SQUARE, MODE_SILENT));
		case ($urandom_range(0, 9))
			0:       plen = INDEX_W'($urandom_range(0, 1));
			1:       plen = INDEX_W'($urandom_range(2, 3));
			7:       plen = INDEX_W'($urandom_range(201, 2000));
			8:       plen = '1;
			9:       plen = INDEX_W'($urandom_range(1, 65535));
			default: plen = INDEX_W'($urandom_range(4, 200));
		endcase
		case ($urandom_range(0, 9))
			0:       g = '1;
			1:       g = GAIN_W'($urandom_range(0, 1));
			default: g = GAIN_W'($urandom_range(2, 32767));
		endcase
		quarter = int'(plen >> 2);
		if (quarter == 0) begin
			quarter = 1;
		end
		case ($urandom_range(0, 9))
			0:       st = '0;
			1:       st = '1;
			2:       st = STEP_W'($urandom);
			// well-formed: one full swing per period, give or take one
			default: st = STEP_W'(int'(g) / quarter + $urandom_range(0, 1));
		endcase
		case ($urandom_range(0, 9))
			0:       ps = '0;
			1:       ps = '1;
			2:       ps = $urandom;
			default: ps = (plen == 0) ? $urandom : PHASE_BITS'(64'h1_0000_0000 / plen);
		endcase
		apply_setting(m, plen, g, st, ps);
	endtask

	// output side: random stalls, one long hold-off on request
	initial begin
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				holds++;
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	initial begin
		int directed;
		int phase_no;
		int n;
		tick.valid   <= 1'b0;
		tick.restart <= 1'b0;
		cfg_wr_en    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		arst_n       <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register values after reset
		repeat (5) send_tick(1'b0);
		// period now below the running index, full-scale square
		apply_setting(MODE_SQUARE, 16'd2, 15'h7fff, 15'd0, 32'd0);
		repeat (3) send_tick(1'b0);
		// zero period and zero gain
		apply_setting(MODE_SQUARE, 16'd0, 15'd0, 15'h7fff, 32'hffff_ffff);
		repeat (2) send_tick(1'b0);
		// triangle reflecting at a tiny gain
		apply_setting(MODE_TRIANGLE, 16'd40, 15'd3, 15'd2, 32'd0);
		send_tick(1'b1);
		repeat (4) send_tick(1'b0);
		// largest step and gain
		apply_setting(MODE_TRIANGLE, 16'hffff, 15'h7fff, 15'h7fff, 32'd0);
		repeat (3) send_tick(1'b0);
		// sine on quadrant boundaries, wrap on the fifth word
		apply_setting(MODE_SINE, 16'd5, 15'h7fff, 15'd0, 32'h4000_0000);
		send_tick(1'b1);
		repeat (4) send_tick(1'b0);
		apply_setting(MODE_SILENT, 16'd1, 15'd1, 15'd1, 32'h8000_0000);
		repeat (2) send_tick(1'b0);
		directed = ticks_sent;

		phase_no = 0;
		while (ticks_sent < directed + RANDOM_TICKS) begin
			random_setting();
			hold_req = (phase_no == 3);
			steady   = (phase_no == 6);
			n        = steady ? 200 : $urandom_range(20, 120);
			repeat (n) send_tick($urandom_range(0, 99) < 3);
			steady = 1'b0;
			phase_no++;
		end

		drain();
		repeat (4) @(posedge clk);
		$display("%0d ticks over %0d register settings, %0d words checked, %0d period wraps",
			ticks_sent, settings_used, checked, wraps);
		$display("all four modes with restarts, %0d output hold-off(s) of %0d cycles",
			holds, HOLD_CYCLES);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

endmodule
